// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the term table block.
// No dependencies; assertions compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: hdl/sptt_pkg.sv
// Package for the sparse polynomial term table: field widths, defaults and codes.
// Used by sparse_polynomial_term_table_core; depends on nothing.
package sptt_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int MAX_POWER_DEF = 31;

  localparam int KIND_W = 2;
  localparam int PWR_W  = 5;
  localparam int COEF_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_EVAL   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// File: hdl/sparse_polynomial_term_table_core.sv
// Sparse polynomial term table: sorted (power, coefficient) store with insert,
// read, remove and evaluate, run by one sequencer around a shared multiplier.
// Depends on sptt_pkg and assert_macros.svh.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one command per transaction;
//   in_kind selects insert, read, remove or evaluate. Each command yields one
//   result transaction on out_valid/out_ready with status, value, power_out and
//   the number of terms held afterwards.
//   in_ready is high only while the sequencer is idle; one command is worked on
//   at a time. Terms sit in two memories (powers, coefficients) with one read
//   and one write port, so every table walk handles one entry at a time.
//   Read fetches one entry; remove moves every entry above the position down;
//   insert compares entries up to the sorted slot, then shifts the ones above
//   it up; evaluate builds x^e for each term by repeated multiplication in the
//   one 32x32 multiplier, then forms coef*x^e and adds it.
//   The result goes into an output register; the next command can be taken
//   while that result still waits, and a stalled receiver only holds the
//   sequencer in its final step until the register frees up.
//   After reset the table is empty; memory contents are not cleared, as only
//   entries below the term count are ever read.
`include "assert_macros.svh"

module sparse_polynomial_term_table_core
  import sptt_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int MAX_POWER = MAX_POWER_DEF,
  localparam int CW = $clog2(MAX_TERMS + 1),
  localparam int IW = $clog2(MAX_TERMS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [PWR_W-1:0]         in_term_power,
  input  logic signed [COEF_W-1:0] in_term_coef,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [COEF_W-1:0] in_x_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [COEF_W-1:0] out_value,
  output logic [PWR_W-1:0]         out_power_out,
  output logic [CW-1:0]            out_term_count
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SEARCH, S_SCHK, S_SHIFT_RD, S_SHIFT_WR, S_RD_WAIT,
    S_REM_RD, S_REM_WR, S_EV_RD, S_EV_LD, S_EV_MUL, S_EV_PROD, S_EV_ADD, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [PWR_W-1:0]    p_r, p_nxt;
  logic [COEF_W-1:0]   c_r, c_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [COEF_W-1:0]   x_r, x_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [PWR_W-1:0]    k_r, k_nxt;
  logic [PWR_W-1:0]    exp_r, exp_nxt;
  logic [COEF_W-1:0]   coef_r, coef_nxt;
  logic [COEF_W-1:0]   pwr_r, pwr_nxt;
  logic [COEF_W-1:0]   acc_r, acc_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [COEF_W-1:0]   res_value_r, res_value_nxt;
  logic [PWR_W-1:0]    res_pw_r, res_pw_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COEF_W-1:0]   out_value_r, out_value_nxt;
  logic [PWR_W-1:0]    out_pw_r, out_pw_nxt;
  logic [CW-1:0]       out_count_r, out_count_nxt;

  // Term memories with registered read data.
  logic [PWR_W-1:0]    pw_mem [MAX_TERMS];
  logic [COEF_W-1:0]   cf_mem [MAX_TERMS];
  logic [PWR_W-1:0]    rd_pw_r;
  logic [COEF_W-1:0]   rd_cf_r;
  logic [IW-1:0]       mem_raddr;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [PWR_W-1:0]    mem_wpw;
  logic [COEF_W-1:0]   mem_wcf;

  // Shared multiplier: x times running power, or coefficient times x^e.
  // Only the low word of the product is kept, which gives the wrapped result.
  logic [COEF_W-1:0]   mul_a;
  logic [COEF_W-1:0]   mul_lo;

  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic                table_full;

  assign mul_a    = (state_r == S_EV_PROD) ? coef_r : x_r;
  assign mul_lo   = mul_a * pwr_r;

  assign pos_ext    = CMPW'(pos_r);
  assign cnt_ext    = CMPW'(count_r);
  assign table_full = (32'(count_r) == 32'(MAX_TERMS));

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value      = $signed(out_value_r);
  assign out_power_out  = out_pw_r;
  assign out_term_count = out_count_r;

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pw_mem[mem_waddr] <= mem_wpw;
      cf_mem[mem_waddr] <= mem_wcf;
    end
    rd_pw_r <= pw_mem[mem_raddr];
    rd_cf_r <= cf_mem[mem_raddr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    p_nxt          = p_r;
    c_nxt          = c_r;
    pos_nxt        = pos_r;
    x_nxt          = x_r;
    count_nxt      = count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    exp_nxt        = exp_r;
    coef_nxt       = coef_r;
    pwr_nxt        = pwr_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_pw_nxt     = res_pw_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pw_nxt     = out_pw_r;
    out_count_nxt  = out_count_r;
    mem_raddr      = i_r[IW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = i_r[IW-1:0];
    mem_wpw        = rd_pw_r;
    mem_wcf        = rd_cf_r;

    // The receiver taking the result frees the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = kind_t'(in_kind);
          p_nxt     = in_term_power;
          c_nxt     = $unsigned(in_term_coef);
          pos_nxt   = in_position;
          x_nxt     = $unsigned(in_x_value);
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_status_nxt = ST_OK;
        res_value_nxt  = '0;
        res_pw_nxt     = '0;
        unique case (kind_r)
          KIND_INSERT: begin
            if (32'(p_r) > 32'(MAX_POWER)) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              i_nxt     = '0;
              state_nxt = S_SEARCH;
            end
          end
          KIND_READ, KIND_REMOVE: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else if (pos_ext >= cnt_ext) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end else if (kind_r == KIND_READ) begin
              mem_raddr = pos_ext[IW-1:0];
              state_nxt = S_RD_WAIT;
            end else begin
              i_nxt     = CW'(pos_ext);
              state_nxt = S_REM_RD;
            end
          end
          KIND_EVAL: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              i_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = S_EV_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // Walk up the sorted table until the power is reached or passed.
      S_SEARCH: begin
        if (i_r == count_r) begin
          if (table_full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            j_nxt     = count_r;
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          mem_raddr = i_r[IW-1:0];
          state_nxt = S_SCHK;
        end
      end

      S_SCHK: begin
        if (rd_pw_r < p_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SEARCH;
        end else if (rd_pw_r == p_r) begin
          // Same power already held: merge the coefficient with wrap.
          mem_we    = 1'b1;
          mem_waddr = i_r[IW-1:0];
          mem_wpw   = rd_pw_r;
          mem_wcf   = rd_cf_r + c_r;
          state_nxt = S_DONE;
        end else if (table_full) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          j_nxt     = count_r;
          state_nxt = S_SHIFT_RD;
        end
      end

      // Open a gap at the insert point, moving entries up from the top.
      S_SHIFT_RD: begin
        if (j_r == i_r) begin
          mem_we    = 1'b1;
          mem_waddr = i_r[IW-1:0];
          mem_wpw   = p_r;
          mem_wcf   = c_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_raddr = IW'(j_r - CW'(1));
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[IW-1:0];
        j_nxt     = j_r - CW'(1);
        state_nxt = S_SHIFT_RD;
      end

      S_RD_WAIT: begin
        res_value_nxt = rd_cf_r;
        res_pw_nxt    = rd_pw_r;
        state_nxt     = S_DONE;
      end

      // Close the gap left by a removed entry, moving entries down.
      S_REM_RD: begin
        if ((i_r + CW'(1)) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_raddr = IW'(i_r + CW'(1));
          state_nxt = S_REM_WR;
        end
      end

      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[IW-1:0];
        i_nxt     = i_r + CW'(1);
        state_nxt = S_REM_RD;
      end

      // Evaluation: fetch a term, build x^e, scale by the coefficient, add.
      S_EV_RD: begin
        if (i_r == count_r) begin
          res_value_nxt = acc_r;
          state_nxt     = S_DONE;
        end else begin
          mem_raddr = i_r[IW-1:0];
          state_nxt = S_EV_LD;
        end
      end

      S_EV_LD: begin
        coef_nxt  = rd_cf_r;
        exp_nxt   = rd_pw_r;
        pwr_nxt   = COEF_W'(1);
        k_nxt     = '0;
        state_nxt = S_EV_MUL;
      end

      S_EV_MUL: begin
        if (k_r == exp_r) begin
          state_nxt = S_EV_PROD;
        end else begin
          pwr_nxt = mul_lo;
          k_nxt   = k_r + PWR_W'(1);
        end
      end

      S_EV_PROD: begin
        pwr_nxt   = mul_lo;
        state_nxt = S_EV_ADD;
      end

      S_EV_ADD: begin
        acc_nxt   = acc_r + pwr_r;
        i_nxt     = i_r + CW'(1);
        state_nxt = S_EV_RD;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_pw_nxt     = res_pw_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    p_r          <= p_nxt;
    c_r          <= c_nxt;
    pos_r        <= pos_nxt;
    x_r          <= x_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    exp_r        <= exp_nxt;
    coef_r       <= coef_nxt;
    pwr_r        <= pwr_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_pw_r     <= res_pw_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pw_r     <= out_pw_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Checks on the sequencer and the term count.
  `ASSERT_NEVER(a_count_bound, clk, rst_n, 32'(count_r) > 32'(MAX_TERMS), "term count above capacity")
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "ready right after accept")
  `ASSERT_CLK(a_full_status, clk, rst_n, (state_r == S_DONE && res_status_r == ST_FULL) |-> table_full, "full status with room left")
  `ASSERT_CLK(a_count_step, clk, rst_n, ($past(rst_n) && count_r != $past(count_r)) |-> (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)), "count moved by more than one")

endmodule

// File: verif/sptt_tb_pkg.sv
// Scoreboard for the sparse polynomial term table: a predictor of the sorted
// term table and an in-order store of the results it expects.
// Depends on sptt_pkg.
package sptt_tb_pkg;
  import sptt_pkg::*;

  localparam int TABLE_DEPTH = MAX_TERMS_DEF;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // One command transaction as it crosses the input channel.
  typedef struct {
    kind_t             kind;
    logic [PWR_W-1:0]  power;
    logic [COEF_W-1:0] coef;
    logic [POS_W-1:0]  position;
    logic [COEF_W-1:0] x;
  } term_cmd_t;

  // One result transaction as it crosses the output channel.
  typedef struct {
    status_t           status;
    logic [COEF_W-1:0] value;
    logic [PWR_W-1:0]  power;
    logic [CNT_W-1:0]  count;
  } term_result_t;

  class term_table_scoreboard;
    // Predicted table contents; only entries below n_terms are meaningful.
    logic [PWR_W-1:0]  powers [TABLE_DEPTH];
    logic [COEF_W-1:0] coefs [TABLE_DEPTH];
    int                n_terms;
    term_result_t      pending_results[$];
    int                mismatches;
    int                results_checked;
    int                kind_hits[4];
    int                status_hits[4];

    // Update the predicted table with an accepted command and queue its result.
    function void apply_command(term_cmd_t c);
      term_result_t      r;
      int                slot;
      int                j;
      logic [COEF_W-1:0] x_pow;
      r.status = ST_OK;
      r.value  = '0;
      r.power  = '0;
      kind_hits[c.kind]++;
      case (c.kind)
        KIND_INSERT: begin
          // Find the sorted slot, then merge or open a gap for the new term.
          slot = 0;
          while (slot < n_terms && powers[slot] < c.power) slot++;
          if (slot < n_terms && powers[slot] == c.power) begin
            coefs[slot] = coefs[slot] + c.coef;
          end else if (n_terms >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (j = n_terms; j > slot; j--) begin
              powers[j] = powers[j-1];
              coefs[j]  = coefs[j-1];
            end
            powers[slot] = c.power;
            coefs[slot]  = c.coef;
            n_terms++;
          end
        end
        KIND_READ, KIND_REMOVE: begin
          if (n_terms == 0) begin
            r.status = ST_EMPTY;
          end else if (int'(c.position) >= n_terms) begin
            r.status = ST_RANGE;
          end else if (c.kind == KIND_READ) begin
            r.value = coefs[c.position];
            r.power = powers[c.position];
          end else begin
            // Close the gap left by the removed term.
            for (j = int'(c.position); j + 1 < n_terms; j++) begin
              powers[j] = powers[j+1];
              coefs[j]  = coefs[j+1];
            end
            n_terms--;
          end
        end
        default: begin
          // Evaluation: sum of coef * x^power, all wrapping at 32 bits.
          if (n_terms == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (j = 0; j < n_terms; j++) begin
              x_pow = 32'd1;
              repeat (powers[j]) x_pow = x_pow * c.x;
              r.value = r.value + coefs[j] * x_pow;
            end
          end
        end
      endcase
      r.count = CNT_W'(n_terms);
      status_hits[r.status]++;
      pending_results.push_back(r);
    endfunction

    // Compare a received result with the oldest expectation.
    function void compare_result(term_result_t got);
      term_result_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status=%0d value=%h power=%0d count=%0d",
                   got.status, got.value, got.power, got.count);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.value !== want.value ||
          got.power !== want.power || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs: expected status=%0d value=%h power=%0d count=%0d, got status=%0d value=%h power=%0d count=%0d",
                   results_checked, want.status, want.value, want.power, want.count,
                   got.status, got.value, got.power, got.count);
        end
      end
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
// Top level of the term table testbench: clock, reset, command driver, result
// receiver with random stalls, and the final verdict.
// Depends on sptt_pkg, sptt_tb_pkg and sparse_polynomial_term_table_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sptt_pkg::*;
  import sptt_tb_pkg::*;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

  localparam int RANDOM_CMDS = 500;
  localparam int HOLD_OFF_AT = 150;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind = '0;
  logic [PWR_W-1:0]         in_term_power = '0;
  logic signed [COEF_W-1:0] in_term_coef = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [COEF_W-1:0] in_x_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [COEF_W-1:0] out_value;
  logic [PWR_W-1:0]         out_power_out;
  logic [CNT_W-1:0]         out_term_count;

  term_table_scoreboard sb = new();
  int cmds_sent;

  sparse_polynomial_term_table_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_term_power (in_term_power),
    .in_term_coef  (in_term_coef),
    .in_position   (in_position),
    .in_x_value    (in_x_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value     (out_value),
    .out_power_out (out_power_out),
    .out_term_count(out_term_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle cycles per transaction; every third stretch of 40 runs with no idling.
  function automatic int idle_cycles(int idx);
    return ((idx / 40) % 3 == 2) ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic term_cmd_t build_cmd(kind_t k, int pw, logic [31:0] cf, int pos,
                                          logic [31:0] x);
    term_cmd_t c;
    c.kind     = k;
    c.power    = PWR_W'(pw);
    c.coef     = cf;
    c.position = POS_W'(pos);
    c.x        = x;
    return c;
  endfunction

  // Random command shaped by the current phase and the predicted table.
  function automatic term_cmd_t random_command(phase_t ph);
    term_cmd_t c;
    int        roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_GROW:   c.kind = kind_t'(roll < 60 ? KIND_INSERT : roll < 75 ? KIND_READ :
                                  roll < 82 ? KIND_REMOVE : KIND_EVAL);
      PH_SHRINK: c.kind = kind_t'(roll < 10 ? KIND_INSERT : roll < 30 ? KIND_READ :
                                  roll < 80 ? KIND_REMOVE : KIND_EVAL);
      default:   c.kind = kind_t'(roll % 4);
    endcase
    // Reuse a held power now and then so merges happen often.
    if (sb.n_terms > 0 && $urandom_range(0, 9) < 3) begin
      c.power = sb.powers[$urandom_range(0, sb.n_terms - 1)];
    end else begin
      c.power = PWR_W'($urandom_range(0, 31));
    end
    if ($urandom_range(0, 3) == 0) c.coef = 32'($urandom_range(0, 8) - 4);
    else c.coef = $urandom();
    if (sb.n_terms > 0 && $urandom_range(0, 3) != 0) begin
      c.position = POS_W'($urandom_range(0, sb.n_terms - 1));
    end else begin
      c.position = POS_W'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 1) == 0) c.x = 32'($urandom_range(0, 6) - 3);
    else c.x = $urandom();
    return c;
  endfunction

  // Offer one command transaction and wait until the block takes it.
  task automatic send_command(term_cmd_t c);
    int gap;
    gap = idle_cycles(cmds_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= c.kind;
    in_term_power <= c.power;
    in_term_coef  <= c.coef;
    in_position   <= c.position;
    in_x_value    <= c.x;
    do @(posedge clk); while (!in_ready);
    sb.apply_command(c);
    cmds_sent++;
  endtask

  // Stimulus: directed corner cases, then phased random traffic.
  initial begin
    phase_t ph;
    int     phase_left;
    int     rand_sent;
    int     waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Evaluate, read and remove on an empty table.
    send_command(build_cmd(KIND_EVAL, 0, 0, 0, 32'd5));
    send_command(build_cmd(KIND_READ, 0, 0, 0, 0));
    send_command(build_cmd(KIND_REMOVE, 0, 0, 0, 0));
    // Extreme powers and coefficients, a wrapping merge and a merge to zero.
    send_command(build_cmd(KIND_INSERT, 0, 32'h7FFF_FFFF, 0, 0));
    send_command(build_cmd(KIND_INSERT, 31, 32'h8000_0000, 0, 0));
    send_command(build_cmd(KIND_INSERT, 0, 32'd1, 0, 0));
    send_command(build_cmd(KIND_INSERT, 31, 32'h8000_0000, 0, 0));
    send_command(build_cmd(KIND_READ, 0, 0, 1, 0));
    send_command(build_cmd(KIND_REMOVE, 0, 0, 15, 0));
    // Power zero at x of zero, and x at minus one.
    send_command(build_cmd(KIND_EVAL, 0, 0, 0, 32'd0));
    send_command(build_cmd(KIND_EVAL, 0, 0, 0, 32'hFFFF_FFFF));
    // Fill the table from the top down so every insert shifts entries.
    for (int p = 14; p >= 1; p--) begin
      send_command(build_cmd(KIND_INSERT, p, $urandom(), 0, 0));
    end
    send_command(build_cmd(KIND_INSERT, 20, 32'd9, 0, 0));
    send_command(build_cmd(KIND_EVAL, 0, 0, 0, 32'h8000_0000));
    send_command(build_cmd(KIND_REMOVE, 0, 0, 0, 0));
    send_command(build_cmd(KIND_READ, 0, 0, 15, 0));

    // Random traffic in phases that grow, drain or mix the table.
    rand_sent = 0;
    while (rand_sent < RANDOM_CMDS) begin
      ph = phase_t'($urandom_range(0, 2));
      phase_left = $urandom_range(20, 40);
      while (phase_left > 0 && rand_sent < RANDOM_CMDS) begin
        send_command(random_command(ph));
        phase_left--;
        rand_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow a long evaluation's worth of cycles.
    waited = 0;
    while (sb.pending_results.size() > 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (700) @(posedge clk);

    if (sb.pending_results.size() > 0) begin
      $display("%0d expected results never arrived", sb.pending_results.size());
    end
    $display("Ran %0d commands: %0d inserts, %0d reads, %0d removes, %0d evaluations.",
             cmds_sent, sb.kind_hits[KIND_INSERT], sb.kind_hits[KIND_READ],
             sb.kind_hits[KIND_REMOVE], sb.kind_hits[KIND_EVAL]);
    $display("Checked %0d results: %0d ok, %0d empty, %0d out of range, %0d full; %0d bad.",
             sb.results_checked, sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_RANGE], sb.status_hits[ST_FULL], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result receiver with random stalls and one long hold-off to back up the block.
  initial begin
    int           stall;
    term_result_t got;
    repeat (3) @(posedge clk);
    forever begin
      stall = (sb.results_checked == HOLD_OFF_AT) ? HOLD_OFF_CYCLES
                                                   : idle_cycles(sb.results_checked);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status = status_t'(out_status);
      got.value  = out_value;
      got.power  = out_power_out;
      got.count  = out_term_count;
      sb.compare_result(got);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
